// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Shared types, register indexes, the substitution table and the round
// functions used by the key schedule and the round cells.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int MaxRounds = 10;
    localparam int CfgIdxW   = 2;

    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    typedef logic [3:0]         round_t;
    typedef logic [127:0]       block_t;
    typedef logic [0:15][7:0]   bytes_t;
    typedef logic [MaxRounds:0][127:0] round_keys_t;

    localparam cfg_idx_t REG_KEY_HIGH    = 2'd0;
    localparam cfg_idx_t REG_KEY_LOW     = 2'd1;
    localparam cfg_idx_t REG_ROUND_COUNT = 2'd2;

    localparam round_t ROUNDS_RESET = 4'd10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t sub_shift(input block_t d);
        bytes_t s;
        bytes_t t;
        s = bytes_t'(d);
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
            end
        end
        return block_t'(t);
    endfunction

    function automatic block_t mix_columns(input block_t d);
        bytes_t s;
        bytes_t t;
        s = bytes_t'(d);
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4 * c + r] = xtime(s[4 * c + r]) ^ xtime(s[4 * c + (r + 1) % 4])
                             ^ s[4 * c + (r + 1) % 4] ^ s[4 * c + (r + 2) % 4]
                             ^ s[4 * c + (r + 3) % 4];
            end
        end
        return block_t'(t);
    endfunction

    function automatic block_t next_round_key(input block_t k, input logic [7:0] rcon);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t  = t ^ {rcon, 24'h000000};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== hw/rtl/aes_in_if.sv =====
// ----------------------------------------------------------------------------
// AES plaintext channel
// Valid/ready channel that carries one plaintext block per beat.
// ----------------------------------------------------------------------------
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_high;
    logic [63:0] plain_low;

    modport source (output valid, output plain_high, output plain_low, input ready);
    modport sink (input valid, input plain_high, input plain_low, output ready);
endinterface

// ===== hw/rtl/aes_out_if.sv =====
// ----------------------------------------------------------------------------
// AES ciphertext channel
// Valid/ready channel that carries one ciphertext block per beat.
// ----------------------------------------------------------------------------
interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;

    modport source (output valid, output cipher_high, output cipher_low, input ready);
    modport sink (input valid, input cipher_high, input cipher_low, output ready);
endinterface

// ===== hw/rtl/aes_cfg_if.sv =====
// ----------------------------------------------------------------------------
// AES configuration channel
// Valid/ready write channel that carries a register index and data per beat.
// ----------------------------------------------------------------------------
interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Encrypts one 128-bit block per beat with AES-128 in codebook form.
// ----------------------------------------------------------------------------
// The block is a row of eleven cells, the initial key addition and one cell
// per round, so it takes a new plaintext beat every cycle while the output is
// not stalled and the key schedule is not busy, and every beat passes all
// eleven cells whatever the round count; cells beyond the programmed round
// count pass the block through. After reset and after each write of a key
// register the key schedule expands the round keys, one per cycle while no
// configuration write arrives, and takes no plaintext during that time.
module aes128_block_encrypt (
    input  logic      clk,
    input  logic      rst_n,
    aes_cfg_if.sink   cfg,
    aes_in_if.sink    plain,
    aes_out_if.source cipher
);
    import aes_pkg::*;

    localparam int Cells = MaxRounds + 1;

    round_keys_t round_keys;
    round_t      rounds;
    logic        busy;
    logic        c_valid [Cells+1];
    logic        c_ready [Cells+1];
    block_t      c_data  [Cells+1];

    aes_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .round_keys (round_keys),
        .rounds     (rounds),
        .busy       (busy)
    );

    assign c_valid[0]       = plain.valid && !busy;
    assign c_data[0]        = {plain.plain_high, plain.plain_low};
    assign plain.ready      = c_ready[0] && !busy;
    assign c_ready[Cells]   = cipher.ready;
    assign cipher.valid     = c_valid[Cells];
    assign cipher.cipher_high = c_data[Cells][127:64];
    assign cipher.cipher_low  = c_data[Cells][63:0];

    for (genvar k = 0; k < Cells; k++)
    begin : g_cell
        aes_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .round_idx (4'(k)),
            .rounds    (rounds),
            .round_key (round_keys[k]),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_data   (c_data[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_data  (c_data[k+1])
        );
    end

endmodule

// ===== hw/rtl/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the configuration registers and expands the round keys, one round
// key per cycle while no write arrives, after reset and after every key write.
// ----------------------------------------------------------------------------
module aes_key_sched (
    input  logic                 clk,
    input  logic                 rst_n,
    aes_cfg_if.sink              cfg,
    output aes_pkg::round_keys_t round_keys,
    output aes_pkg::round_t      rounds,
    output logic                 busy
);
    import aes_pkg::*;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    round_t       count_reg;
    block_t       cur_reg;
    block_t       cur_next;
    logic [7:0]   rcon_reg;
    round_t       cnt_reg;
    logic         busy_reg;
    block_t       rk_reg [1:MaxRounds];
    logic         wr_key;

    assign cfg.ready = 1'b1;
    assign wr_key    = cfg.valid && (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW);
    assign cur_next  = next_round_key(cur_reg, rcon_reg);
    assign busy      = busy_reg;

    always_comb
    begin
        round_keys[0] = {key_high_reg, key_low_reg};
        for (int i = 1; i <= MaxRounds; i++)
        begin
            round_keys[i] = rk_reg[i];
        end
        if (count_reg == 4'd0)
        begin
            rounds = 4'd1;
        end
        else if (count_reg > 4'(MaxRounds))
        begin
            rounds = 4'(MaxRounds);
        end
        else
        begin
            rounds = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            count_reg    <= ROUNDS_RESET;
            cur_reg      <= '0;
            rcon_reg     <= 8'h01;
            cnt_reg      <= 4'd1;
            busy_reg     <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KEY_HIGH:    key_high_reg <= cfg.data;
                REG_KEY_LOW:     key_low_reg  <= cfg.data;
                REG_ROUND_COUNT: count_reg    <= cfg.data[3:0];
                default:         ;
            endcase
            if (wr_key)
            begin
                cur_reg  <= (cfg.index == REG_KEY_HIGH) ? {cfg.data, key_low_reg}
                                                         : {key_high_reg, cfg.data};
                rcon_reg <= 8'h01;
                cnt_reg  <= 4'd1;
                busy_reg <= 1'b1;
            end
        end
        else if (busy_reg)
        begin
            cur_reg  <= cur_next;
            rcon_reg <= xtime(rcon_reg);
            cnt_reg  <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(MaxRounds))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg.valid)
        begin
            rk_reg[cnt_reg] <= cur_next;
        end
    end

endmodule

// ===== hw/rtl/aes_cell.sv =====
// ----------------------------------------------------------------------------
// AES round cell
// One pipeline cell: applies its round (initial key addition, or none past
// the round count) to the block it takes in and holds it for the next cell.
// ----------------------------------------------------------------------------
module aes_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  aes_pkg::round_t round_idx,
    input  aes_pkg::round_t rounds,
    input  aes_pkg::block_t round_key,
    input  logic            in_valid,
    output logic            in_ready,
    input  aes_pkg::block_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output aes_pkg::block_t out_data
);
    import aes_pkg::*;

    logic   valid_reg;
    block_t data_reg;
    block_t data_next;
    block_t sub_data;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign sub_data  = sub_shift(in_data);

    always_comb
    begin
        if (round_idx == 4'd0)
        begin
            data_next = in_data ^ round_key;
        end
        else if (round_idx > rounds)
        begin
            data_next = in_data;
        end
        else if (round_idx == rounds)
        begin
            data_next = sub_data ^ round_key;
        end
        else
        begin
            data_next = mix_columns(sub_data) ^ round_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
